// ----- hdl/sjft_pkg.sv -----
// Shared types and constants of the shortest-job-first timing block.
`default_nettype none

package sjft_pkg;

   localparam int ID_W    = 16;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 20;
   localparam int CLOCK_W = 21;
   localparam int SUM_W   = 23;
   localparam int ENTRY_W = ID_W + BURST_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_RD_I,
      ST_LD_I,
      ST_CMP,
      ST_WR_I,
      ST_RD_K,
      ST_EMIT
   } sjft_state_type;

   typedef struct packed {
      logic accept;
      logic rd_i;
      logic ld_i;
      logic cmp;
      logic wr_i;
      logic rd_k;
      logic emit;
   } sjft_cmd_type;

   typedef struct packed {
      logic single_task;
      logic more_j;
      logic more_i;
      logic last_k;
      logic out_free;
   } sjft_status_type;

endpackage

`default_nettype wire

// ----- hdl/shortest_job_first_timing.sv -----
// Loading: one word a cycle until the last word of a set; then a start state, then for n >= 2
//   stored tasks an exchange sort (one compare a cycle on one port).
// After the sort (after the start state for one task), states RD_K and EMIT register the first
//   result word, then one result word a cycle when the response side does not stall.
// The next set is accepted only once the last result word has been registered.
// Reset: synchronous, active high; clears counts, flags, timers and the result valid.
`default_nettype none

module shortest_job_first_timing import sjft_pkg::*; #(
   parameter int MAX_TASKS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input words: one task each
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [ID_W-1:0]    req_task_id,
   input  wire logic [BURST_W-1:0] req_burst_time,
   input  wire logic               req_last_task,
   // result words: one per scheduled task
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [ID_W-1:0]         rsp_sched_task_id,
   output logic [TIME_W-1:0]       rsp_start_time,
   output logic [TIME_W-1:0]       rsp_end_time,
   output logic [TIME_W-1:0]       rsp_wait_time,
   output logic [SUM_W-1:0]        rsp_total_wait,
   output logic                    rsp_last_result,
   output logic                    rsp_dropped_flag
);

   // Commands flow from the sequencer to the datapath; status flows back.
   sjft_cmd_type    cmd;
   sjft_status_type status;

   // The sequencer holds the input side stalled from the last word of a set
   // until the last result has been loaded into the output register.
   sjft_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_task (req_last_task),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // The datapath owns the task store, the held entry of the sort, the
   // running clock and wait sum, and the result register that decouples
   // the response side from the sequencer.
   sjft_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_task_id       (req_task_id),
      .req_burst_time    (req_burst_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sched_task_id (rsp_sched_task_id),
      .rsp_start_time    (rsp_start_time),
      .rsp_end_time      (rsp_end_time),
      .rsp_wait_time     (rsp_wait_time),
      .rsp_total_wait    (rsp_total_wait),
      .rsp_last_result   (rsp_last_result),
      .rsp_dropped_flag  (rsp_dropped_flag)
   );

endmodule

`default_nettype wire

// ----- hdl/sjft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sjft_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/sjft_datapath.sv -----
// Datapath: task store, sort registers, timing accumulators and result register.
`default_nettype none

module sjft_datapath import sjft_pkg::*; #(
   parameter int MAX_TASKS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sjft_cmd_type         cmd,
   output sjft_status_type           status,
   input  wire logic [ID_W-1:0]      req_task_id,
   input  wire logic [BURST_W-1:0]   req_burst_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ID_W-1:0]           rsp_sched_task_id,
   output logic [TIME_W-1:0]         rsp_start_time,
   output logic [TIME_W-1:0]         rsp_end_time,
   output logic [TIME_W-1:0]         rsp_wait_time,
   output logic [SUM_W-1:0]          rsp_total_wait,
   output logic                      rsp_last_result,
   output logic                      rsp_dropped_flag
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int CMP_W = CNT_W + 1;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [ID_W-1:0]    cur_id_ff, cur_id_in;
   logic [BURST_W-1:0] cur_burst_ff, cur_burst_in;
   logic [CLOCK_W-1:0] time_ff, time_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [ID_W-1:0]    rsp_id_ff;
   logic [TIME_W-1:0]  rsp_start_ff;
   logic [TIME_W-1:0]  rsp_end_ff;
   logic [SUM_W-1:0]   rsp_sum_ff;
   logic               rsp_last_ff;
   logic               rsp_drop_ff;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [ID_W-1:0]    rd_id;
   logic [BURST_W-1:0] rd_burst;

   logic               full;
   logic               swap;
   logic [CMP_W-1:0]   count_ext, i_ext, j_ext, k_ext;
   logic [IDX_W-1:0]   i_plus, j_plus, k_plus;
   logic [CLOCK_W-1:0] time_add;
   logic [SUM_W-1:0]   sum_add;

   sjft_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id    = rd_data[ENTRY_W-1:BURST_W];
   assign rd_burst = rd_data[BURST_W-1:0];

   assign full      = (count_ff == CNT_W'(MAX_TASKS));
   assign swap      = (cur_burst_ff > rd_burst);
   assign count_ext = {1'b0, count_ff};
   assign i_ext     = CMP_W'(i_ff);
   assign j_ext     = CMP_W'(j_ff);
   assign k_ext     = CMP_W'(k_ff);
   assign i_plus    = i_ff + IDX_W'(1);
   assign j_plus    = j_ff + IDX_W'(1);
   assign k_plus    = k_ff + IDX_W'(1);
   assign time_add  = time_ff + CLOCK_W'(rd_burst);
   assign sum_add   = sum_ff + SUM_W'(time_ff);

   always_comb begin
      status.single_task = (count_ff == CNT_W'(1));
      status.more_j      = ((j_ext + CMP_W'(1)) < count_ext);
      status.more_i      = ((i_ext + CMP_W'(2)) < count_ext);
      status.last_k      = ((k_ext + CMP_W'(1)) == count_ext);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Read port: one address a cycle; the next entry is fetched while this one is used.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = i_ff;
      if (cmd.rd_i) begin
         rd_en   = 1'b1;
         rd_addr = i_ff;
      end else if (cmd.ld_i) begin
         rd_en   = 1'b1;
         rd_addr = i_plus;
      end else if (cmd.cmp) begin
         rd_en   = status.more_j;
         rd_addr = j_plus;
      end else if (cmd.wr_i) begin
         rd_en   = status.more_i;
         rd_addr = i_plus;
      end else if (cmd.rd_k) begin
         rd_en   = 1'b1;
         rd_addr = k_ff;
      end else if (cmd.emit) begin
         rd_en   = !status.last_k;
         rd_addr = k_plus;
      end
   end

   // Write port: load a new task, drop the held entry into j on a swap, settle slot i.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff;
      wr_data = {cur_id_ff, cur_burst_ff};
      if (cmd.accept) begin
         wr_en   = !full;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = {req_task_id, req_burst_time};
      end else if (cmd.cmp) begin
         wr_en   = swap;
         wr_addr = j_ff;
      end else if (cmd.wr_i) begin
         wr_en   = 1'b1;
         wr_addr = i_ff;
      end
   end

   always_comb begin
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cur_id_in    = cur_id_ff;
      cur_burst_in = cur_burst_ff;
      time_in      = time_ff;
      sum_in       = sum_ff;
      if (cmd.accept) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.ld_i) begin
         cur_id_in    = rd_id;
         cur_burst_in = rd_burst;
         j_in         = i_plus;
      end
      if (cmd.cmp) begin
         if (swap) begin
            cur_id_in    = rd_id;
            cur_burst_in = rd_burst;
         end
         if (status.more_j) begin
            j_in = j_plus;
         end
      end
      if (cmd.wr_i) begin
         i_in = i_plus;
      end
      if (cmd.emit) begin
         time_in = time_add;
         sum_in  = sum_add;
         k_in    = k_plus;
         if (status.last_k) begin
            count_in    = '0;
            overflow_in = 1'b0;
            time_in     = '0;
            sum_in      = '0;
            i_in        = '0;
            k_in        = '0;
         end
      end
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         time_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         time_ff      <= time_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_id_ff    <= cur_id_in;
      cur_burst_ff <= cur_burst_in;
      if (cmd.emit) begin
         rsp_id_ff    <= rd_id;
         rsp_start_ff <= time_ff[TIME_W-1:0];
         rsp_end_ff   <= time_add[TIME_W-1:0];
         rsp_sum_ff   <= sum_add;
         rsp_last_ff  <= status.last_k;
         rsp_drop_ff  <= overflow_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sched_task_id = rsp_id_ff;
   assign rsp_start_time    = rsp_start_ff;
   assign rsp_end_time      = rsp_end_ff;
   assign rsp_wait_time     = rsp_start_ff;
   assign rsp_total_wait    = rsp_sum_ff;
   assign rsp_last_result   = rsp_last_ff;
   assign rsp_dropped_flag  = rsp_drop_ff;

endmodule

`default_nettype wire

// ----- hdl/sjft_controller.sv -----
// Controller: sequences loading, the exchange sort and result emission.
`default_nettype none

module sjft_controller import sjft_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_last_task,
   output logic                 req_stall,
   input  wire sjft_status_type status,
   output sjft_cmd_type         cmd
);

   sjft_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last_task) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = status.single_task ? ST_RD_K : ST_RD_I;
         end
         ST_RD_I: begin
            state_in = ST_LD_I;
         end
         ST_LD_I: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = status.more_j ? ST_CMP : ST_WR_I;
         end
         ST_WR_I: begin
            state_in = status.more_i ? ST_LD_I : ST_RD_K;
         end
         ST_RD_K: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && status.last_k) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_START: begin
         end
         ST_RD_I: begin
            cmd.rd_i = 1'b1;
         end
         ST_LD_I: begin
            cmd.ld_i = 1'b1;
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
         end
         ST_WR_I: begin
            cmd.wr_i = 1'b1;
         end
         ST_RD_K: begin
            cmd.rd_k = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/sjft_checker.sv -----
// Port-level checks of the shortest-job-first timing block and their binding.
`default_nettype none

module sjft_checker import sjft_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               req_last_task,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [ID_W-1:0]    rsp_sched_task_id,
   input wire logic [TIME_W-1:0]  rsp_start_time,
   input wire logic [TIME_W-1:0]  rsp_end_time,
   input wire logic [TIME_W-1:0]  rsp_wait_time,
   input wire logic [SUM_W-1:0]   rsp_total_wait,
   input wire logic               rsp_last_result,
   input wire logic               rsp_dropped_flag
);

   // Hold a stalled result word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sched_task_id)
         && $stable(rsp_start_time) && $stable(rsp_end_time)
         && $stable(rsp_wait_time) && $stable(rsp_total_wait)
         && $stable(rsp_last_result) && $stable(rsp_dropped_flag))
      else $error("stalled result word changed");

   // Stall the input once the last word of a set has been taken.
   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_task |=> req_stall)
      else $error("input not stalled after last word of a set");

   // Waiting time always matches the start time.
   a_wait_is_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wait_time == rsp_start_time)
      else $error("wait time differs from start time");

   // No result word right out of reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind shortest_job_first_timing sjft_checker u_sjft_checker (.*);

`default_nettype wire
